@@ sv/tlc_pkg.sv @@
`timescale 1ns / 1ps
package tlc_pkg;

    localparam int ADDR_W      = 48;
    localparam int LINE_W      = 48;
    localparam int LAT_W       = 18;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int L1_WAYS     = 8;
    localparam int L2_WAYS     = 16;
    localparam int L1_MAX_SETS = 64;
    localparam int L2_MAX_SETS = 1024;
    localparam int L1_SET_W    = $clog2(L1_MAX_SETS);
    localparam int L2_SET_W    = $clog2(L2_MAX_SETS);
    localparam int L1_FILL_W   = $clog2(L1_WAYS + 1);
    localparam int L2_FILL_W   = $clog2(L2_WAYS + 1);
    localparam int L1_DEPTH    = 2 * L1_MAX_SETS;
    localparam int CNT_W       = $clog2(ADDR_W);
    localparam int CLR_W       = $clog2(L2_MAX_SETS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_BYTES   = 4'd0,
        REG_L1I_SETS     = 4'd1,
        REG_L1D_SETS     = 4'd2,
        REG_L2_SETS      = 4'd3,
        REG_L1I_LATENCY  = 4'd4,
        REG_L1D_LATENCY  = 4'd5,
        REG_L2_LATENCY   = 4'd6,
        REG_DRAM_LATENCY = 4'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_L1_READ,
        ST_L1_CHECK,
        ST_L2_READ,
        ST_L2_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [L1_FILL_W-1:0]           fill;
        logic [L1_WAYS-1:0][LINE_W-1:0] ways;
    } l1_row_t;

    typedef struct packed {
        logic [L2_FILL_W-1:0]           fill;
        logic [L2_WAYS-1:0][LINE_W-1:0] ways;
    } l2_row_t;

endpackage

@@ sv/tlc_if.sv @@
`timescale 1ns / 1ps
interface tlc_req_if;
    import tlc_pkg::*;
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [ADDR_W-1:0] address;
    modport source (output valid, output opcode, output address, input ready);
    modport sink (input valid, input opcode, input address, output ready);
endinterface

interface tlc_rsp_if;
    import tlc_pkg::*;
    logic              valid;
    logic              ready;
    logic [LAT_W-1:0]  total_latency;
    logic              first_level_miss;
    logic              second_level_miss;
    logic [LINE_W-1:0] line_number;
    modport source (output valid, output total_latency, output first_level_miss,
                    output second_level_miss, output line_number, input ready);
    modport sink (input valid, input total_latency, input first_level_miss,
                  input second_level_miss, input line_number, output ready);
endinterface

interface tlc_cfg_if;
    import tlc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/two_level_lru_cache_latency_model.sv @@
`timescale 1ns / 1ps
// channel  dir  payload                                                  beat when
// req      in   opcode, address                                          valid && ready
// rsp      out  total_latency, first_level_miss, second_level_miss,      valid && ready
//               line_number
// cfg      in   index, data                                              valid && ready
//
// an access divides the address bit-serially by the line size (set indexes are
// reduced in the same loop), then for each cache level reads the tag row and
// writes it back; l2 is read only on an l1 miss
// after reset a clearing pass zeroes the fill counts; req is held off
// cfg is always ready; a result waiting on rsp stalls only the end of the next access
module two_level_lru_cache_latency_model (
    input  logic     clk,
    input  logic     rst_n,
    tlc_req_if.sink  req,
    tlc_rsp_if.source rsp,
    tlc_cfg_if.sink  cfg
);
    import tlc_pkg::*;

    logic [15:0] line_size_reg, l1i_lat_reg, l1d_lat_reg, l2_lat_reg, dram_lat_reg;
    logic [6:0]  l1i_sets_reg, l1d_sets_reg;
    logic [10:0] l2_sets_reg;

    state_t state_reg, state_next;
    logic [CLR_W-1:0]  clr_reg, clr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              op_reg, op_next;
    logic [ADDR_W-1:0] quo_reg, quo_next;
    logic [15:0]       rem_reg, rem_next;
    logic [15:0]       div_reg, div_next;
    logic [L1_SET_W-1:0] m1_reg, m1_next;
    logic [L2_SET_W-1:0] m2_reg, m2_next;
    logic [L1_SET_W:0]   s1_reg, s1_next;
    logic [L2_SET_W:0]   s2_reg, s2_next;
    logic [LAT_W-1:0]  lat_reg, lat_next;
    logic              l1m_reg, l1m_next, l2m_reg, l2m_next;
    logic              ov_reg, ov_next;
    logic [LAT_W-1:0]  o_lat_reg, o_lat_next;
    logic              o_l1m_reg, o_l1m_next, o_l2m_reg, o_l2m_next;
    logic [LINE_W-1:0] o_line_reg, o_line_next;

    logic                      l1_we, l2_we;
    logic [L1_SET_W:0]         l1_addr;
    logic [L2_SET_W-1:0]       l2_addr;
    l1_row_t                   l1_wrow, l1_rrow, l1_upd;
    l2_row_t                   l2_wrow, l2_rrow, l2_upd;
    logic                      l1_hit, l2_hit;

    tlc_ram #(.WIDTH($bits(l1_row_t)), .DEPTH(L1_DEPTH)) u_l1_ram (
        .clk(clk), .we(l1_we), .addr(l1_addr), .wdata(l1_wrow), .rdata(l1_rrow)
    );

    tlc_ram #(.WIDTH($bits(l2_row_t)), .DEPTH(L2_MAX_SETS)) u_l2_ram (
        .clk(clk), .we(l2_we), .addr(l2_addr), .wdata(l2_wrow), .rdata(l2_rrow)
    );

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_size_reg  <= 16'd64;
            l1i_sets_reg   <= 7'd64;
            l1d_sets_reg   <= 7'd64;
            l2_sets_reg    <= 11'd1024;
            l1i_lat_reg    <= 16'd4;
            l1d_lat_reg    <= 16'd4;
            l2_lat_reg     <= 16'd12;
            dram_lat_reg   <= 16'd100;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_LINE_BYTES:   line_size_reg  <= cfg.data;
                REG_L1I_SETS:     l1i_sets_reg   <= cfg.data[6:0];
                REG_L1D_SETS:     l1d_sets_reg   <= cfg.data[6:0];
                REG_L2_SETS:      l2_sets_reg    <= cfg.data[10:0];
                REG_L1I_LATENCY:  l1i_lat_reg    <= cfg.data;
                REG_L1D_LATENCY:  l1d_lat_reg    <= cfg.data;
                REG_L2_LATENCY:   l2_lat_reg     <= cfg.data;
                REG_DRAM_LATENCY: dram_lat_reg   <= cfg.data;
                default: ;
            endcase
        end
    end

    // lru row update, l1
    always_comb
    begin
        logic [L1_FILL_W-1:0] n, k, hp;
        logic [L1_WAYS-1:0]   hv;
        n = (l1_rrow.fill > L1_FILL_W'(L1_WAYS)) ? L1_FILL_W'(L1_WAYS) : l1_rrow.fill;
        hp = '0;
        for (int p = 0; p < L1_WAYS; p++)
        begin
            hv[p] = (L1_FILL_W'(p) < n) && (l1_rrow.ways[p] == quo_reg);
        end
        for (int p = L1_WAYS - 1; p >= 0; p--)
        begin
            if (hv[p])
            begin
                hp = L1_FILL_W'(p);
            end
        end
        l1_hit = |hv;
        if (l1_hit)
        begin
            k = hp;
        end
        else
        begin
            k = (n < L1_FILL_W'(L1_WAYS)) ? n : L1_FILL_W'(L1_WAYS - 1);
        end
        l1_upd.ways[0] = quo_reg;
        for (int q = 1; q < L1_WAYS; q++)
        begin
            l1_upd.ways[q] = (L1_FILL_W'(q) <= k) ? l1_rrow.ways[q-1] : l1_rrow.ways[q];
        end
        if (l1_hit)
        begin
            l1_upd.fill = l1_rrow.fill;
        end
        else
        begin
            l1_upd.fill = (n < L1_FILL_W'(L1_WAYS)) ? n + 1'b1 : L1_FILL_W'(L1_WAYS);
        end
    end

    // lru row update, l2
    always_comb
    begin
        logic [L2_FILL_W-1:0] n, k, hp;
        logic [L2_WAYS-1:0]   hv;
        n = (l2_rrow.fill > L2_FILL_W'(L2_WAYS)) ? L2_FILL_W'(L2_WAYS) : l2_rrow.fill;
        hp = '0;
        for (int p = 0; p < L2_WAYS; p++)
        begin
            hv[p] = (L2_FILL_W'(p) < n) && (l2_rrow.ways[p] == quo_reg);
        end
        for (int p = L2_WAYS - 1; p >= 0; p--)
        begin
            if (hv[p])
            begin
                hp = L2_FILL_W'(p);
            end
        end
        l2_hit = |hv;
        if (l2_hit)
        begin
            k = hp;
        end
        else
        begin
            k = (n < L2_FILL_W'(L2_WAYS)) ? n : L2_FILL_W'(L2_WAYS - 1);
        end
        l2_upd.ways[0] = quo_reg;
        for (int q = 1; q < L2_WAYS; q++)
        begin
            l2_upd.ways[q] = (L2_FILL_W'(q) <= k) ? l2_rrow.ways[q-1] : l2_rrow.ways[q];
        end
        if (l2_hit)
        begin
            l2_upd.fill = l2_rrow.fill;
        end
        else
        begin
            l2_upd.fill = (n < L2_FILL_W'(L2_WAYS)) ? n + 1'b1 : L2_FILL_W'(L2_WAYS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        op_reg     <= op_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        m1_reg     <= m1_next;
        m2_reg     <= m2_next;
        s1_reg     <= s1_next;
        s2_reg     <= s2_next;
        lat_reg    <= lat_next;
        l1m_reg    <= l1m_next;
        l2m_reg    <= l2m_next;
        o_lat_reg  <= o_lat_next;
        o_l1m_reg  <= o_l1m_next;
        o_l2m_reg  <= o_l2m_next;
        o_line_reg <= o_line_next;
    end

    always_comb
    begin
        logic [16:0]         rt;
        logic                qb;
        logic [L1_SET_W:0]   t1;
        logic [L2_SET_W:0]   t2;
        logic [6:0]          sets1;
        state_next  = state_reg;
        clr_next    = clr_reg;
        cnt_next    = cnt_reg;
        op_next     = op_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        m1_next     = m1_reg;
        m2_next     = m2_reg;
        s1_next     = s1_reg;
        s2_next     = s2_reg;
        lat_next    = lat_reg;
        l1m_next    = l1m_reg;
        l2m_next    = l2m_reg;
        ov_next     = ov_reg && !rsp.ready;
        o_lat_next  = o_lat_reg;
        o_l1m_next  = o_l1m_reg;
        o_l2m_next  = o_l2m_reg;
        o_line_next = o_line_reg;
        req.ready   = 1'b0;
        l1_we       = 1'b0;
        l2_we       = 1'b0;
        l1_addr     = {op_reg, m1_reg};
        l2_addr     = m2_reg;
        l1_wrow     = l1_upd;
        l2_wrow     = l2_upd;
        rt = {rem_reg, quo_reg[ADDR_W-1]};
        qb = (rt >= {1'b0, div_reg});
        t1 = {m1_reg, qb};
        t2 = {m2_reg, qb};
        sets1 = req.opcode ? l1d_sets_reg : l1i_sets_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                l1_addr = clr_reg[L1_SET_W:0];
                l2_addr = clr_reg;
                l1_wrow = '0;
                l2_wrow = '0;
                l1_we   = (clr_reg < CLR_W'(L1_DEPTH));
                l2_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_W'(L2_MAX_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    op_next  = req.opcode;
                    quo_next = req.address;
                    rem_next = '0;
                    div_next = (line_size_reg == 16'd0) ? 16'd1 : line_size_reg;
                    m1_next  = '0;
                    m2_next  = '0;
                    cnt_next = '0;
                    if (sets1 == 7'd0)
                    begin
                        s1_next = (L1_SET_W + 1)'(1);
                    end
                    else if (sets1 > 7'(L1_MAX_SETS))
                    begin
                        s1_next = (L1_SET_W + 1)'(L1_MAX_SETS);
                    end
                    else
                    begin
                        s1_next = (L1_SET_W + 1)'(sets1);
                    end
                    if (l2_sets_reg == 11'd0)
                    begin
                        s2_next = (L2_SET_W + 1)'(1);
                    end
                    else if (l2_sets_reg > 11'(L2_MAX_SETS))
                    begin
                        s2_next = (L2_SET_W + 1)'(L2_MAX_SETS);
                    end
                    else
                    begin
                        s2_next = (L2_SET_W + 1)'(l2_sets_reg);
                    end
                    lat_next   = LAT_W'(req.opcode ? l1d_lat_reg : l1i_lat_reg);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // one quotient bit per beat, set indexes folded in msb first
                rem_next = qb ? 16'(rt - {1'b0, div_reg}) : rt[15:0];
                quo_next = {quo_reg[ADDR_W-2:0], qb};
                m1_next  = (t1 >= s1_reg) ? L1_SET_W'(t1 - s1_reg) : L1_SET_W'(t1);
                m2_next  = (t2 >= s2_reg) ? L2_SET_W'(t2 - s2_reg) : L2_SET_W'(t2);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ADDR_W - 1))
                begin
                    state_next = ST_L1_READ;
                end
            end
            ST_L1_READ:
            begin
                state_next = ST_L1_CHECK;
            end
            ST_L1_CHECK:
            begin
                l1_we    = 1'b1;
                l1m_next = !l1_hit;
                l2m_next = 1'b0;
                if (l1_hit)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    lat_next   = lat_reg + LAT_W'(l2_lat_reg);
                    state_next = ST_L2_READ;
                end
            end
            ST_L2_READ:
            begin
                state_next = ST_L2_CHECK;
            end
            ST_L2_CHECK:
            begin
                l2_we    = 1'b1;
                l2m_next = !l2_hit;
                if (!l2_hit)
                begin
                    lat_next = lat_reg + LAT_W'(dram_lat_reg);
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next     = 1'b1;
                    o_lat_next  = lat_reg;
                    o_l1m_next  = l1m_reg;
                    o_l2m_next  = l2m_reg;
                    o_line_next = quo_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.valid             = ov_reg;
    assign rsp.total_latency     = o_lat_reg;
    assign rsp.first_level_miss  = o_l1m_reg;
    assign rsp.second_level_miss = o_l2m_reg;
    assign rsp.line_number       = o_line_reg;

endmodule

@@ sv/tlc_ram.sv @@
`timescale 1ns / 1ps
module tlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
